// ===== rtl/bkmh_pkg.sv =====
// shared types, constants and sequencer states for the bottom-k max-heap
`default_nettype none
package bkmh_pkg;

  localparam int unsigned WORD_W       = 64;
  localparam int unsigned IDX_W        = 6;
  localparam int unsigned HEAP_SIZE_DEF = 64;

  localparam logic [1:0] CMD_OFFER = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [WORD_W-1:0] EMPTY_WORD = {WORD_W{1'b1}};

  typedef struct packed {
    logic [1:0]        command;
    logic [WORD_W-1:0] value;
    logic [IDX_W-1:0]  slot_index;
  } bkmh_in_t;

  typedef struct packed {
    logic              accepted;
    logic [WORD_W-1:0] current_max;
    logic [WORD_W-1:0] read_value;
  } bkmh_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SIFT_RD,
    ST_SIFT_CMP,
    ST_SLOT_RD,
    ST_SLOT_OUT
  } bkmh_state_t;

endpackage
`default_nettype wire

// ===== rtl/bottom_k_max_heap.sv =====
// top level: bottom-k selection max-heap, a shared compare unit and three-port slot memory
//
// Keeps the HEAP_SIZE smallest 64-bit values offered, as a max-heap in an on-chip memory
// whose root is mirrored in a register. An item is taken when start is high and busy low;
// its single result appears one cycle wide on out_valid and cannot be held off, so it must
// be captured when it shows. A rejected offer or an unused command returns its result the
// cycle after acceptance. An accepted offer replaces the root and sifts it down; each level
// descended is a memory read of both children, then a compare and write back, as the
// memory read data is registered. A slot read passes through a memory read state and an
// output state. A clear sweeps one slot a cycle. After reset the same sweep runs with busy
// high and no result.
`default_nettype none
module bottom_k_max_heap #(
  parameter int unsigned HEAP_SIZE = bkmh_pkg::HEAP_SIZE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire bkmh_pkg::bkmh_in_t in_data,
  output logic                    out_valid,
  output bkmh_pkg::bkmh_out_t     out_data
);

  localparam int unsigned AW = (HEAP_SIZE > 1) ? $clog2(HEAP_SIZE) : 1;
  localparam int unsigned CW = AW + 2;
  localparam int unsigned W  = bkmh_pkg::WORD_W;
  localparam bit SLOT_ALL = (HEAP_SIZE >= (1 << bkmh_pkg::IDX_W));
  localparam logic [bkmh_pkg::IDX_W-1:0] SLOT_LIM =
    bkmh_pkg::IDX_W'(SLOT_ALL ? 0 : HEAP_SIZE);
  localparam logic [CW-1:0] HEAP_C   = CW'(HEAP_SIZE);
  localparam logic [AW-1:0] LAST_IDX = AW'(HEAP_SIZE - 1);

  logic [W-1:0] mem [HEAP_SIZE];

  bkmh_pkg::bkmh_state_t state_r, state_nxt;
  bkmh_pkg::bkmh_in_t    item_r;
  logic [AW-1:0]         pos_r;
  logic [AW-1:0]         cnt_r;
  logic [W-1:0]          root_r;
  logic                  emit_clr_r;
  logic [W-1:0]          rda_q, rdb_q;
  logic                  out_valid_r;
  bkmh_pkg::bkmh_out_t   out_r;

  logic          accept;
  logic [CW-1:0] left_c, right_c;
  logic          left_in, right_in, pick_right, sift_stop, slot_ok;
  logic [W-1:0]  big_val;
  logic [AW-1:0] big_idx;

  logic          mem_we;
  logic [AW-1:0] mem_wa, rd_a_addr, rd_b_addr;
  logic [W-1:0]  mem_wd, root_nxt;
  logic          emit;
  bkmh_pkg::bkmh_out_t emit_data;

  assign busy      = (state_r != bkmh_pkg::ST_IDLE);
  assign accept    = start && (state_r == bkmh_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // shared compare unit: children of the current position
  assign left_c     = CW'({pos_r, 1'b1});
  assign right_c    = left_c + CW'(1);
  assign left_in    = left_c < HEAP_C;
  assign right_in   = right_c < HEAP_C;
  assign pick_right = right_in && (rdb_q > rda_q);
  assign big_val    = pick_right ? rdb_q : rda_q;
  assign big_idx    = pick_right ? right_c[AW-1:0] : left_c[AW-1:0];
  assign sift_stop  = !left_in || (item_r.value >= big_val);
  assign slot_ok    = SLOT_ALL || (item_r.slot_index < SLOT_LIM);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bkmh_pkg::ST_CLEAR: begin
        if (cnt_r == LAST_IDX) state_nxt = bkmh_pkg::ST_IDLE;
      end
      bkmh_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_data.command)
            bkmh_pkg::CMD_OFFER: begin
              if (in_data.value < root_r) state_nxt = bkmh_pkg::ST_SIFT_RD;
            end
            bkmh_pkg::CMD_READ:  state_nxt = bkmh_pkg::ST_SLOT_RD;
            bkmh_pkg::CMD_CLEAR: state_nxt = bkmh_pkg::ST_CLEAR;
            default:             state_nxt = bkmh_pkg::ST_IDLE;
          endcase
        end
      end
      bkmh_pkg::ST_SIFT_RD:  state_nxt = bkmh_pkg::ST_SIFT_CMP;
      bkmh_pkg::ST_SIFT_CMP: state_nxt = sift_stop ? bkmh_pkg::ST_IDLE : bkmh_pkg::ST_SIFT_RD;
      bkmh_pkg::ST_SLOT_RD:  state_nxt = bkmh_pkg::ST_SLOT_OUT;
      bkmh_pkg::ST_SLOT_OUT: state_nxt = bkmh_pkg::ST_IDLE;
      default:               state_nxt = bkmh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wa    = pos_r;
    mem_wd    = item_r.value;
    rd_a_addr = left_c[AW-1:0];
    rd_b_addr = right_c[AW-1:0];
    emit      = 1'b0;
    emit_data = '0;
    unique case (state_r)
      bkmh_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = cnt_r;
        mem_wd = bkmh_pkg::EMPTY_WORD;
        emit   = emit_clr_r && (cnt_r == LAST_IDX);
      end
      bkmh_pkg::ST_IDLE: begin
        // rejected offers and the unused command answer at once
        if (accept && in_data.command != bkmh_pkg::CMD_READ &&
            in_data.command != bkmh_pkg::CMD_CLEAR &&
            !(in_data.command == bkmh_pkg::CMD_OFFER && in_data.value < root_r)) begin
          emit = 1'b1;
        end
      end
      bkmh_pkg::ST_SIFT_RD: ;
      bkmh_pkg::ST_SIFT_CMP: begin
        mem_we             = 1'b1;
        mem_wd             = sift_stop ? item_r.value : big_val;
        emit               = sift_stop;
        emit_data.accepted = 1'b1;
      end
      bkmh_pkg::ST_SLOT_RD: begin
        rd_a_addr = AW'(item_r.slot_index);
      end
      bkmh_pkg::ST_SLOT_OUT: begin
        emit                 = 1'b1;
        emit_data.read_value = slot_ok ? rda_q : '0;
      end
      default: ;
    endcase
    root_nxt = (mem_we && mem_wa == '0) ? mem_wd : root_r;
    emit_data.current_max = root_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rda_q <= mem[rd_a_addr];
    rdb_q <= mem[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bkmh_pkg::ST_CLEAR;
      cnt_r       <= '0;
      emit_clr_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
      if (state_r == bkmh_pkg::ST_CLEAR) cnt_r <= cnt_r + AW'(1);
      if (accept) begin
        cnt_r      <= '0;
        emit_clr_r <= (in_data.command == bkmh_pkg::CMD_CLEAR);
      end
    end
  end

  always_ff @(posedge clk) begin
    root_r <= root_nxt;
    if (emit) out_r <= emit_data;
    if (accept) begin
      item_r <= in_data;
      pos_r  <= '0;
    end else if (state_r == bkmh_pkg::ST_SIFT_CMP && !sift_stop) begin
      pos_r <= big_idx;
    end
  end

endmodule
`default_nettype wire

// ===== sim/bottom_k_max_heap_tb.sv =====
// self-checking bench for the bottom-k max-heap: directed table, then random commands in phases
module bottom_k_max_heap_tb;

  localparam int unsigned HEAP_N     = bkmh_pkg::HEAP_SIZE_DEF;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam int          RAND_ITEMS = 480;
  localparam int          MAX_REPORT = 10;

  typedef struct {
    bkmh_pkg::bkmh_in_t  item;
    bit                  typed;
    bkmh_pkg::bkmh_out_t want;
  } heap_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  bkmh_pkg::bkmh_in_t  in_data = '0;
  logic                out_valid;
  bkmh_pkg::bkmh_out_t out_data;

  logic [bkmh_pkg::WORD_W-1:0] heap_model [HEAP_N];
  bkmh_pkg::bkmh_out_t         pending_results [$];
  heap_row_t                   directed_rows [$];
  bkmh_pkg::bkmh_out_t         oldest;

  int mismatch_count = 0;
  int results_seen = 0;
  int items_sent = 0;
  int offers_kept = 0;
  int offers_dropped = 0;
  int reads_sent = 0;
  int clears_sent = 0;

  bottom_k_max_heap #(.HEAP_SIZE(HEAP_N)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // replace-root-and-sift-down heap, one command at a time
  function automatic bkmh_pkg::bkmh_out_t apply_to_heap(bkmh_pkg::bkmh_in_t it);
    bkmh_pkg::bkmh_out_t r;
    int unsigned         pos;
    int unsigned         lc;
    int unsigned         rc;
    int unsigned         big;
    bit                  done;
    r = '0;
    case (it.command)
      bkmh_pkg::CMD_OFFER: begin
        if (it.value < heap_model[0]) begin
          pos = 0;
          done = 1'b0;
          while (!done) begin
            lc = 2 * pos + 1;
            rc = lc + 1;
            if (lc >= HEAP_N) begin
              done = 1'b1;
            end else begin
              big = lc;
              // right child wins only when strictly larger
              if (rc < HEAP_N && heap_model[rc] > heap_model[lc]) big = rc;
              if (it.value >= heap_model[big]) begin
                done = 1'b1;
              end else begin
                heap_model[pos] = heap_model[big];
                pos = big;
              end
            end
          end
          heap_model[pos] = it.value;
          r.accepted = 1'b1;
        end
      end
      bkmh_pkg::CMD_READ: begin
        if (it.slot_index < HEAP_N) r.read_value = heap_model[it.slot_index];
      end
      bkmh_pkg::CMD_CLEAR: begin
        foreach (heap_model[i]) heap_model[i] = bkmh_pkg::EMPTY_WORD;
      end
      default: begin
      end
    endcase
    r.current_max = heap_model[0];
    return r;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input logic [bkmh_pkg::WORD_W-1:0] val,
                         input logic [bkmh_pkg::IDX_W-1:0] idx, input bit typed,
                         input logic acc, input logic [bkmh_pkg::WORD_W-1:0] cur_max,
                         input logic [bkmh_pkg::WORD_W-1:0] rd);
    heap_row_t row;
    row.item.command = cmd;
    row.item.value = val;
    row.item.slot_index = idx;
    row.typed = typed;
    row.want.accepted = acc;
    row.want.current_max = cur_max;
    row.want.read_value = rd;
    directed_rows = {directed_rows, row};
  endtask

  function automatic bkmh_pkg::bkmh_in_t random_item();
    bkmh_pkg::bkmh_in_t          it;
    int unsigned                 roll;
    logic [bkmh_pkg::WORD_W-1:0] root;
    root = heap_model[0];
    it.value = {$urandom, $urandom};
    it.slot_index = bkmh_pkg::IDX_W'($urandom_range(HEAP_N - 1));
    roll = $urandom_range(99);
    if (roll < 72) it.command = bkmh_pkg::CMD_OFFER;
    else if (roll < 94) it.command = bkmh_pkg::CMD_READ;
    else if (roll < 95) it.command = bkmh_pkg::CMD_CLEAR;
    else it.command = CMD_UNUSED;
    if (it.command == bkmh_pkg::CMD_OFFER) begin
      case ($urandom_range(9))
        3, 4: it.value = bkmh_pkg::WORD_W'($urandom_range(15)); // small pool forces sift ties
        5: it.value = root;
        6: it.value = root - 1;
        7: it.value = root + 1;
        8: it.value = bkmh_pkg::EMPTY_WORD;
        9: it.value = it.value >> $urandom_range(63);
        default: begin
        end
      endcase
    end
    return it;
  endfunction

  // sender holds start low for a random stretch
  task automatic idle_gap(input int unsigned pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < pct);
    end
  endtask

  // present one item, wait for the handshake, then log what the heap should return
  task automatic send_item(input bkmh_pkg::bkmh_in_t it, input bit typed,
                           input bkmh_pkg::bkmh_out_t typed_want);
    bkmh_pkg::bkmh_out_t predicted;
    in_data <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predicted = apply_to_heap(it);
    if (typed) pending_results = {pending_results, typed_want};
    else pending_results = {pending_results, predicted};
    items_sent++;
    case (it.command)
      bkmh_pkg::CMD_OFFER: begin
        if (predicted.accepted) offers_kept++;
        else offers_dropped++;
      end
      bkmh_pkg::CMD_READ: reads_sent++;
      bkmh_pkg::CMD_CLEAR: clears_sent++;
      default: begin
      end
    endcase
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORT)
          $display("unexpected result: acc=%0b max=%h rd=%h",
                   out_data.accepted, out_data.current_max, out_data.read_value);
      end else begin
        oldest = pending_results.pop_front();
        if (out_data.accepted !== oldest.accepted ||
            out_data.current_max !== oldest.current_max ||
            out_data.read_value !== oldest.read_value) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORT)
            $display("mismatch: got acc=%0b max=%h rd=%h, expected acc=%0b max=%h rd=%h",
                     out_data.accepted, out_data.current_max, out_data.read_value,
                     oldest.accepted, oldest.current_max, oldest.read_value);
        end
      end
    end
  end

  initial begin
    int unsigned         phase_idle [3];
    int                  phase;
    int                  n;
    int                  drain_cycles;
    bkmh_pkg::bkmh_out_t no_want;
    phase_idle = '{0, 49, 9};
    no_want = '0;
    foreach (heap_model[i]) heap_model[i] = bkmh_pkg::EMPTY_WORD;

    add_row(bkmh_pkg::CMD_READ,  bkmh_pkg::EMPTY_WORD, 6'd0,  1, 1'b0,
            bkmh_pkg::EMPTY_WORD, bkmh_pkg::EMPTY_WORD);
    add_row(bkmh_pkg::CMD_READ,  '0,                   6'd63, 1, 1'b0,
            bkmh_pkg::EMPTY_WORD, bkmh_pkg::EMPTY_WORD);
    add_row(CMD_UNUSED,          bkmh_pkg::EMPTY_WORD, 6'd63, 1, 1'b0,
            bkmh_pkg::EMPTY_WORD, '0);
    // all ones equals the empty root, so it is turned away
    add_row(bkmh_pkg::CMD_OFFER, bkmh_pkg::EMPTY_WORD, 6'd0,  1, 1'b0,
            bkmh_pkg::EMPTY_WORD, '0);
    add_row(bkmh_pkg::CMD_OFFER, '0,                   6'd63, 1, 1'b1,
            bkmh_pkg::EMPTY_WORD, '0);
    add_row(bkmh_pkg::CMD_OFFER, '0,                   6'd0,  1, 1'b1,
            bkmh_pkg::EMPTY_WORD, '0);
    add_row(bkmh_pkg::CMD_OFFER, bkmh_pkg::EMPTY_WORD - 1, 6'd0, 1, 1'b1,
            bkmh_pkg::EMPTY_WORD, '0);
    add_row(bkmh_pkg::CMD_READ,  '0,                   6'd0,  0, 1'b0, '0, '0);
    add_row(bkmh_pkg::CMD_READ,  '0,                   6'd1,  0, 1'b0, '0, '0);
    add_row(bkmh_pkg::CMD_READ,  '0,                   6'd2,  0, 1'b0, '0, '0);
    add_row(bkmh_pkg::CMD_OFFER, 64'h8000_0000_0000_0000, 6'd21, 0, 1'b0, '0, '0);
    add_row(bkmh_pkg::CMD_OFFER, 64'h1,                6'd42, 0, 1'b0, '0, '0);
    add_row(bkmh_pkg::CMD_READ,  '0,                   6'd3,  0, 1'b0, '0, '0);
    add_row(bkmh_pkg::CMD_READ,  '0,                   6'd4,  0, 1'b0, '0, '0);
    add_row(bkmh_pkg::CMD_CLEAR, '0,                   6'd0,  1, 1'b0,
            bkmh_pkg::EMPTY_WORD, '0);
    add_row(bkmh_pkg::CMD_READ,  '0,                   6'd0,  1, 1'b0,
            bkmh_pkg::EMPTY_WORD, bkmh_pkg::EMPTY_WORD);
    add_row(bkmh_pkg::CMD_OFFER, 64'd5,                6'd0,  1, 1'b1,
            bkmh_pkg::EMPTY_WORD, '0);
    add_row(bkmh_pkg::CMD_OFFER, 64'd5,                6'd0,  0, 1'b0, '0, '0);
    add_row(bkmh_pkg::CMD_OFFER, 64'd5,                6'd0,  0, 1'b0, '0, '0);
    add_row(bkmh_pkg::CMD_READ,  '0,                   6'd1,  0, 1'b0, '0, '0);
    add_row(bkmh_pkg::CMD_READ,  '0,                   6'd2,  0, 1'b0, '0, '0);
    add_row(CMD_UNUSED,          '0,                   6'd0,  1, 1'b0,
            bkmh_pkg::EMPTY_WORD, '0);
    add_row(bkmh_pkg::CMD_CLEAR, bkmh_pkg::EMPTY_WORD, 6'd63, 1, 1'b0,
            bkmh_pkg::EMPTY_WORD, '0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      idle_gap(30);
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end
    drain_results();

    for (phase = 0; phase < 3; phase++) begin
      for (n = 0; n < RAND_ITEMS / 3; n++) begin
        idle_gap(phase_idle[phase]);
        send_item(random_item(), 1'b0, no_want);
      end
      // hold off until the heap has answered everything
      drain_results();
    end

    start <= 1'b0;
    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < 2000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (80) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatch_count++;
      $display("%0d results never arrived", pending_results.size());
    end

    $display("sent %0d items: %0d offers kept, %0d turned away, %0d reads, %0d clears",
             items_sent, offers_kept, offers_dropped, reads_sent, clears_sent);
    $display("checked %0d results, %0d failures", results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
